@@ rtl/btlp_pkg.sv @@
// Shared constants and types of the binomial tail log p-value unit.
// Used by the top level and its port checker.
// No dependencies.
package btlp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int N_W        = 12;
    localparam int MAX_TOTAL  = 4095;
    localparam int LF_DEPTH   = MAX_TOTAL + 1;
    localparam int LF_W       = 32;
    localparam int CORR_DEPTH = 1024;
    localparam int CORR_AW    = 10;
    localparam int CORR_W     = 16;
    localparam int LOGP_W     = 29;
    localparam int ACC_W      = 35;
    localparam int SCALE_W    = 24;
    localparam int CTRL_W     = 20;
    localparam int RATIO_W    = 32;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;
    localparam int MUL_W      = 31;
    localparam int PROD_W     = 2 * MUL_W;

    // ln(2) in Q.30, and e^(-1/128) in Q.30 from its truncated series.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [29:0] Y0_Q30  = 30'd1065385899;

    localparam logic [PADDR_W-1:0] ADDR_CONTROL_SCALE = 2'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET        = 24'd65536;

    typedef logic [N_W-1:0] count_t;

endpackage

@@ rtl/btlp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module btlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/binomial_tail_log_p_value_unit.sv @@
// Top level of the binomial tail log p-value unit.
// Depends on btlp_pkg and btlp_ram.
//
// Usage. A request on the input channel carries sample_reads and control_reads;
// it is taken at a clock edge where in_valid is high and in_stall is low. The
// block answers each request with one result on the output channel, held in an
// output register until out_stall is low. control_scale is to be written
// through the APB port only while the block is idle; the block itself does
// not enforce this. pready is always high. After reset the block builds its
// tables: the log-factorial RAM (two copies) and the log-add correction RAM,
// using the shared 31x31 multiplier for the squaring log2 of each entry.
// in_stall is high while the tables are built. control_scale resets to 1.0.
// Each request loops over the tail terms, a+1 of them, where a is the adjusted
// control count. Each term takes a read of both log-factorial copies, a
// subtract, a compare and a correction RAM read; the correction add is skipped
// for a term whose log-add needs no correction.
// The enrichment divider runs up to 32 bit-serial steps before the loop.
// Requests are taken one at a time; a finished result may wait in the output
// register while the next request is already being worked on.
module binomial_tail_log_p_value_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btlp_pkg::PADDR_W-1:0]        paddr,
    input  logic [btlp_pkg::PDATA_W-1:0]        pwdata,
    output logic [btlp_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [btlp_pkg::N_W-1:0]            sample_reads,
    input  logic [btlp_pkg::CTRL_W-1:0]         control_reads,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [btlp_pkg::LOGP_W-1:0]  log_p_value,
    output logic [btlp_pkg::N_W-1:0]            adjusted_control,
    output logic [btlp_pkg::RATIO_W-1:0]        enrichment_ratio,
    output logic                                saturated
);
    import btlp_pkg::*;

    typedef enum logic [24:0] {
        S_LF0     = 25'd1 << 0,
        S_LSTART  = 25'd1 << 1,
        S_SQ      = 25'd1 << 2,
        S_NORM    = 25'd1 << 3,
        S_MULLN   = 25'd1 << 4,
        S_LACC    = 25'd1 << 5,
        S_LWR     = 25'd1 << 6,
        S_INITQ0  = 25'd1 << 7,
        S_INITQ1  = 25'd1 << 8,
        S_CSTART  = 25'd1 << 9,
        S_CWR     = 25'd1 << 10,
        S_CYMUL   = 25'd1 << 11,
        S_CYUP    = 25'd1 << 12,
        S_IDLE    = 25'd1 << 13,
        S_ADJ     = 25'd1 << 14,
        S_DEN     = 25'd1 << 15,
        S_HALF    = 25'd1 << 16,
        S_DIV     = 25'd1 << 17,
        S_LFN     = 25'd1 << 18,
        S_LFNW    = 25'd1 << 19,
        S_TRD     = 25'd1 << 20,
        S_TCALC   = 25'd1 << 21,
        S_LACMP   = 25'd1 << 22,
        S_LAADD   = 25'd1 << 23,
        S_FIN     = 25'd1 << 24
    } state_t;

    localparam logic signed [ACC_W-1:0] LOGP_MIN = -(ACC_W'(1) <<< (LOGP_W - 1));

    // Control state
    state_t state_reg, state_next;
    logic   corr_mode_reg, corr_mode_next;
    logic   acc_valid_reg, acc_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    count_t idx_reg, idx_next;
    logic [4:0] bit_reg, bit_next;
    logic [4:0] div_cnt_reg, div_cnt_next;

    // Payload
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MUL_W-1:0]  m_reg, m_next;
    logic [29:0]       r_reg, r_next;
    logic [3:0]        e_reg, e_next;
    logic [45:0]       acc_q30_reg, acc_q30_next;
    logic [29:0]       y_reg, y_next;
    logic [29:0]       q_reg, q_next;
    count_t            sample_reg, sample_next;
    logic [CTRL_W-1:0] ctrl_reg, ctrl_next;
    count_t            adj_reg, adj_next;
    count_t            n_reg, n_next;
    logic              sat_reg, sat_next;
    logic [43:0]       den_reg, den_next;
    logic [27:0]       half_reg, half_next;
    logic [43:0]       rem_reg, rem_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [LF_W-1:0]   lfn_reg, lfn_next;
    logic signed [ACC_W-1:0] t_reg, t_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] hi_reg, hi_next;
    logic signed [LOGP_W-1:0] logp_out_reg, logp_out_next;
    count_t            adj_out_reg, adj_out_next;
    logic [RATIO_W-1:0] ratio_out_reg, ratio_out_next;
    logic              sat_out_reg, sat_out_next;

    // Shared multiplier
    logic [MUL_W-1:0] mul_a, mul_b;

    // RAM ports
    logic               lf_we;
    count_t             lf_waddr;
    logic [LF_W-1:0]    lf_wdata;
    count_t             lfa_raddr, lfb_raddr;
    logic [LF_W-1:0]    lfa_rdata, lfb_rdata;
    logic               corr_we;
    logic [CORR_AW-1:0] corr_waddr;
    logic [CORR_W-1:0]  corr_wdata;
    logic [CORR_AW-1:0] corr_raddr;
    logic [CORR_W-1:0]  corr_rdata;

    // Helpers
    logic [31:0]  sq_top;
    logic [44:0]  adj_sum;
    logic [20:0]  adj_raw, adj_one;
    count_t       adj_cl;
    logic         adj_sat;
    logic [12:0]  n_raw;
    logic [45:0]  lf_round;
    logic [30:0]  corr_round;
    logic [44:0]  rem_shift;
    logic [44:0]  rem_sub;
    logic [43:0]  rem_init;
    logic [41:0]  half_sum;
    logic signed [ACC_W-1:0] la_hi, la_lo, la_diff;
    logic         cfg_write;
    logic         out_free;
    logic [3:0]   msb_pos;

    always_comb
    begin
        msb_pos = 4'd0;
        for (int b = 1; b < N_W; b++)
        begin
            if (idx_reg[b])
            begin
                msb_pos = 4'(b);
            end
        end
    end

    assign sq_top     = prod_reg[61:30];
    assign adj_sum    = {1'b0, prod_reg[43:0]} + 45'hFF_FFFF;
    assign adj_raw    = adj_sum[44:24];
    assign adj_one    = (adj_raw == 21'd0) ? 21'd1 : adj_raw;
    assign adj_sat    = (adj_one > 21'(MAX_TOTAL));
    assign adj_cl     = adj_sat ? count_t'(MAX_TOTAL) : adj_one[N_W-1:0];
    assign n_raw      = {1'b0, adj_cl} + {1'b0, sample_reg};
    assign lf_round   = acc_q30_reg + 46'd8192;
    assign corr_round = prod_reg[60:30] + 31'd8192;
    assign rem_shift  = {rem_reg, 1'b0};
    assign rem_sub    = rem_shift - {1'b0, den_reg};
    assign rem_init   = {24'd0, sample_reg, 8'd0};
    assign half_sum   = prod_reg[41:0] + 42'd8192;
    assign la_hi      = (acc_reg > t_reg) ? acc_reg : t_reg;
    assign la_lo      = (acc_reg > t_reg) ? t_reg : acc_reg;
    assign la_diff    = la_hi - la_lo;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign out_free   = !out_valid_reg || !out_stall;

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_MULLN:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = {1'b0, LN2_Q30};
            end
            S_INITQ0:
            begin
                mul_a = {1'b0, Y0_Q30};
                mul_b = {1'b0, Y0_Q30};
            end
            S_CYMUL:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, q_reg};
            end
            S_IDLE:
            begin
                mul_a = MUL_W'(control_reads);
                mul_b = MUL_W'(scale_reg);
            end
            S_ADJ:
            begin
                mul_a = (ctrl_reg == '0) ? MUL_W'(256) : MUL_W'(ctrl_reg);
                mul_b = MUL_W'(scale_reg);
            end
            S_DEN:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = {1'b0, LN2_Q30};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        corr_mode_next = corr_mode_reg;
        acc_valid_next = acc_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        scale_next     = cfg_write && (paddr == ADDR_CONTROL_SCALE)
                         ? pwdata[SCALE_W-1:0] : scale_reg;
        idx_next       = idx_reg;
        bit_next       = bit_reg;
        div_cnt_next   = div_cnt_reg;
        prod_next      = mul_a * mul_b;
        m_next         = m_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        acc_q30_next   = acc_q30_reg;
        y_next         = y_reg;
        q_next         = q_reg;
        sample_next    = sample_reg;
        ctrl_next      = ctrl_reg;
        adj_next       = adj_reg;
        n_next         = n_reg;
        sat_next       = sat_reg;
        den_next       = den_reg;
        half_next      = half_reg;
        rem_next       = rem_reg;
        ratio_next     = ratio_reg;
        lfn_next       = lfn_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        hi_next        = hi_reg;
        logp_out_next  = logp_out_reg;
        adj_out_next   = adj_out_reg;
        ratio_out_next = ratio_out_reg;
        sat_out_next   = sat_out_reg;

        lf_we      = 1'b0;
        lf_waddr   = idx_reg;
        lf_wdata   = lf_round[45:14];
        lfa_raddr  = (state_reg == S_LFN) ? n_reg : idx_reg;
        lfb_raddr  = n_reg - idx_reg;
        corr_we    = 1'b0;
        corr_waddr = idx_reg[CORR_AW-1:0];
        corr_wdata = corr_round[29:14];
        corr_raddr = la_diff[CORR_AW+9:10];

        unique case (state_reg)
            S_LF0:
            begin
                lf_we          = 1'b1;
                lf_waddr       = '0;
                lf_wdata       = '0;
                idx_next       = count_t'(1);
                acc_q30_next   = '0;
                corr_mode_next = 1'b0;
                state_next     = S_LSTART;
            end
            S_LSTART:
            begin
                e_next     = msb_pos;
                m_next     = MUL_W'(idx_reg) << (5'd30 - {1'b0, msb_pos});
                r_next     = '0;
                bit_next   = 5'd29;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_NORM;
            end
            S_NORM:
            begin
                // Squaring doubles the log2; a carry past 2.0 yields one result bit.
                if (sq_top[31])
                begin
                    m_next         = sq_top[31:1];
                    r_next[bit_reg] = 1'b1;
                end
                else
                begin
                    m_next = sq_top[30:0];
                end
                if (bit_reg == 5'd0)
                begin
                    state_next = S_MULLN;
                end
                else
                begin
                    bit_next   = bit_reg - 5'd1;
                    state_next = S_SQ;
                end
            end
            S_MULLN:
            begin
                state_next = corr_mode_reg ? S_CWR : S_LACC;
            end
            S_LACC:
            begin
                acc_q30_next = acc_q30_reg + (46'(e_reg) * 46'(LN2_Q30))
                             + 46'(prod_reg[61:30]);
                state_next   = S_LWR;
            end
            S_LWR:
            begin
                lf_we = 1'b1;
                if (idx_reg == count_t'(MAX_TOTAL))
                begin
                    state_next = S_INITQ0;
                end
                else
                begin
                    idx_next   = idx_reg + count_t'(1);
                    state_next = S_LSTART;
                end
            end
            S_INITQ0:
            begin
                y_next     = Y0_Q30;
                state_next = S_INITQ1;
            end
            S_INITQ1:
            begin
                q_next         = prod_reg[59:30];
                idx_next       = '0;
                corr_mode_next = 1'b1;
                state_next     = S_CSTART;
            end
            S_CSTART:
            begin
                m_next     = {1'b1, y_reg};
                r_next     = '0;
                bit_next   = 5'd29;
                state_next = S_SQ;
            end
            S_CWR:
            begin
                corr_we    = 1'b1;
                state_next = S_CYMUL;
            end
            S_CYMUL:
            begin
                state_next = S_CYUP;
            end
            S_CYUP:
            begin
                y_next = prod_reg[59:30];
                if (idx_reg == count_t'(CORR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + count_t'(1);
                    state_next = S_CSTART;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample_reads;
                    ctrl_next   = control_reads;
                    state_next  = S_ADJ;
                end
            end
            S_ADJ:
            begin
                adj_next = adj_cl;
                if (n_raw > 13'(MAX_TOTAL))
                begin
                    n_next   = count_t'(MAX_TOTAL);
                    sat_next = 1'b1;
                end
                else
                begin
                    n_next   = n_raw[N_W-1:0];
                    sat_next = adj_sat;
                end
                state_next = S_DEN;
            end
            S_DEN:
            begin
                den_next   = prod_reg[43:0];
                state_next = S_HALF;
            end
            S_HALF:
            begin
                half_next = half_sum[41:14];
                rem_next  = rem_init;
                state_next = S_LFN;
                if (den_reg == '0)
                begin
                    ratio_next = (sample_reg != '0) ? '1 : '0;
                end
                else if (rem_init >= den_reg)
                begin
                    ratio_next = '1;
                end
                else
                begin
                    ratio_next   = '0;
                    div_cnt_next = 5'd31;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next   = rem_sub[43:0];
                    ratio_next = {ratio_reg[RATIO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next   = rem_shift[43:0];
                    ratio_next = {ratio_reg[RATIO_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0)
                begin
                    state_next = S_LFN;
                end
            end
            S_LFN:
            begin
                state_next = S_LFNW;
            end
            S_LFNW:
            begin
                lfn_next       = lfa_rdata;
                idx_next       = '0;
                acc_valid_next = 1'b0;
                state_next     = S_TRD;
            end
            S_TRD:
            begin
                state_next = S_TCALC;
            end
            S_TCALC:
            begin
                t_next = $signed(ACC_W'(lfn_reg)) - $signed(ACC_W'(lfa_rdata))
                       - $signed(ACC_W'(lfb_rdata)) - $signed(ACC_W'(half_reg));
                state_next = S_LACMP;
            end
            S_LACMP:
            begin
                if (!acc_valid_reg || la_diff[ACC_W-1:CORR_AW+10] != '0)
                begin
                    acc_next       = acc_valid_reg ? la_hi : t_reg;
                    acc_valid_next = 1'b1;
                    if (idx_reg == adj_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + count_t'(1);
                        state_next = S_TRD;
                    end
                end
                else
                begin
                    hi_next    = la_hi;
                    state_next = S_LAADD;
                end
            end
            S_LAADD:
            begin
                acc_next = hi_reg + $signed(ACC_W'(corr_rdata));
                if (idx_reg == adj_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + count_t'(1);
                    state_next = S_TRD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (acc_reg > $signed(ACC_W'(0)))
                    begin
                        logp_out_next = '0;
                    end
                    else if (acc_reg < LOGP_MIN)
                    begin
                        logp_out_next = LOGP_MIN[LOGP_W-1:0];
                    end
                    else
                    begin
                        logp_out_next = acc_reg[LOGP_W-1:0];
                    end
                    adj_out_next   = adj_reg;
                    ratio_out_next = ratio_reg;
                    sat_out_next   = sat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LF0;
            corr_mode_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            scale_reg     <= SCALE_RESET;
            idx_reg       <= '0;
            bit_reg       <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            corr_mode_reg <= corr_mode_next;
            acc_valid_reg <= acc_valid_next;
            out_valid_reg <= out_valid_next;
            scale_reg     <= scale_next;
            idx_reg       <= idx_next;
            bit_reg       <= bit_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        m_reg         <= m_next;
        r_reg         <= r_next;
        e_reg         <= e_next;
        acc_q30_reg   <= acc_q30_next;
        y_reg         <= y_next;
        q_reg         <= q_next;
        sample_reg    <= sample_next;
        ctrl_reg      <= ctrl_next;
        adj_reg       <= adj_next;
        n_reg         <= n_next;
        sat_reg       <= sat_next;
        den_reg       <= den_next;
        half_reg      <= half_next;
        rem_reg       <= rem_next;
        ratio_reg     <= ratio_next;
        lfn_reg       <= lfn_next;
        t_reg         <= t_next;
        acc_reg       <= acc_next;
        hi_reg        <= hi_next;
        logp_out_reg  <= logp_out_next;
        adj_out_reg   <= adj_out_next;
        ratio_out_reg <= ratio_out_next;
        sat_out_reg   <= sat_out_next;
    end

    // Two copies of the log-factorial table give two reads per term.
    btlp_ram #(.WIDTH(LF_W), .DEPTH(LF_DEPTH)) u_lf_a (
        .clk   (clk),
        .we    (lf_we),
        .waddr (lf_waddr),
        .wdata (lf_wdata),
        .raddr (lfa_raddr),
        .rdata (lfa_rdata)
    );

    btlp_ram #(.WIDTH(LF_W), .DEPTH(LF_DEPTH)) u_lf_b (
        .clk   (clk),
        .we    (lf_we),
        .waddr (lf_waddr),
        .wdata (lf_wdata),
        .raddr (lfb_raddr),
        .rdata (lfb_rdata)
    );

    btlp_ram #(.WIDTH(CORR_W), .DEPTH(CORR_DEPTH)) u_corr (
        .clk   (clk),
        .we    (corr_we),
        .waddr (corr_waddr),
        .wdata (corr_wdata),
        .raddr (corr_raddr),
        .rdata (corr_rdata)
    );

    assign pready           = 1'b1;
    assign prdata           = (paddr == ADDR_CONTROL_SCALE) ? PDATA_W'(scale_reg) : '0;
    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign log_p_value      = logp_out_reg;
    assign adjusted_control = adj_out_reg;
    assign enrichment_ratio = ratio_out_reg;
    assign saturated        = sat_out_reg;
endmodule

@@ rtl/btlp_checker.sv @@
// Port-level checker of the binomial tail log p-value unit, with its bind.
// Depends on btlp_pkg and binomial_tail_log_p_value_unit.
module btlp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               pready,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [btlp_pkg::LOGP_W-1:0] log_p_value,
    input logic [btlp_pkg::N_W-1:0]           adjusted_control
);
    import btlp_pkg::*;

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A probability never exceeds one, so its log is never positive.
    a_logp_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (log_p_value[LOGP_W-1] || log_p_value == '0))
        else $error("positive log p-value");

    // The adjusted count is forced to at least one.
    a_adj_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> adjusted_control != '0)
        else $error("adjusted count is zero");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");
endmodule

bind binomial_tail_log_p_value_unit btlp_checker u_btlp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pready           (pready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .log_p_value      (log_p_value),
    .adjusted_control (adjusted_control)
);
